// ----- hw/rtl/tcf_pkg.sv -----
package tcf_pkg;

    // algorithm settings
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;

    // field widths
    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 20;
    localparam int ALPHA_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int RATE_W     = DATA_W + 1;

    // cordic widths
    localparam int XY_W       = 27;
    localparam int ACC_W      = 26;
    localparam int ATAN_W     = 22;
    localparam int ATAN_IDX_W = 5;
    localparam int STEP_W     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PRE_SHIFT  = 8;

    localparam int ROUND_SHIFT = 16 - ANGLE_FRAC_BITS;
    localparam int ROUND_BIAS  = 1 << (15 - ANGLE_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_QUARTER = ACC_W'(90 * 65536);

    // blend widths
    localparam int MUL_W      = 21;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIFF_W     = 38;
    localparam int MIX_W      = 56;
    localparam int Q16_SHIFT  = 16;
    localparam int MIX_SHIFT  = 32;
    localparam int FRAC_SPLIT = 20;
    localparam int SAT_IN_W   = 32;
    localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(64'sd2147483648);

    // register reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(64225);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(320);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_WEIGHT,
        CFG_GYRO_STEP_GAIN,
        CFG_ACCEL_OFFSET_X,
        CFG_ACCEL_OFFSET_Y,
        CFG_ACCEL_OFFSET_Z,
        CFG_RATE_OFFSET_X,
        CFG_RATE_OFFSET_Y
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CORDIC,
        OP_ROUND,
        OP_MUL_RATE,
        OP_DIFF,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_STORE,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic                axis;
        logic [STEP_W-1:0]   step;
    } t_dp_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_ROUND,
        S_MUL_RATE,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_STORE,
        S_OUT
    } t_ctrl_state;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117305;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/tcf_ctrl.sv -----
module tcf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tcf_pkg::t_dp_cmd o_cmd
);

    tcf_pkg::t_ctrl_state             r_state, n_state;
    logic [tcf_pkg::STEP_W-1:0]       r_cnt, n_cnt;
    logic                             r_axis, n_axis;
    logic                             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcf_pkg::S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_axis     = r_axis;
        o_in_ready = 1'b0;
        o_cmd.op   = tcf_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        o_cmd.step = r_cnt;
        case (r_state)
            tcf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = tcf_pkg::OP_LOAD;
                    n_cnt    = '0;
                    n_state  = tcf_pkg::S_CORDIC;
                end
            end
            tcf_pkg::S_CORDIC: begin
                o_cmd.op = tcf_pkg::OP_CORDIC;
                if (r_cnt == tcf_pkg::STEP_W'(tcf_pkg::CORDIC_STEPS - 1)) begin
                    n_state = tcf_pkg::S_ROUND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcf_pkg::S_ROUND: begin
                o_cmd.op = tcf_pkg::OP_ROUND;
                n_axis   = 1'b0;
                n_state  = tcf_pkg::S_MUL_RATE;
            end
            tcf_pkg::S_MUL_RATE: begin
                o_cmd.op = tcf_pkg::OP_MUL_RATE;
                n_state  = tcf_pkg::S_DIFF;
            end
            tcf_pkg::S_DIFF: begin
                o_cmd.op = tcf_pkg::OP_DIFF;
                n_state  = tcf_pkg::S_MUL_LO;
            end
            tcf_pkg::S_MUL_LO: begin
                o_cmd.op = tcf_pkg::OP_MUL_LO;
                n_state  = tcf_pkg::S_MUL_HI;
            end
            tcf_pkg::S_MUL_HI: begin
                o_cmd.op = tcf_pkg::OP_MUL_HI;
                n_state  = tcf_pkg::S_ACC;
            end
            tcf_pkg::S_ACC: begin
                o_cmd.op = tcf_pkg::OP_ACC;
                n_state  = tcf_pkg::S_STORE;
            end
            tcf_pkg::S_STORE: begin
                o_cmd.op = tcf_pkg::OP_STORE;
                if (r_axis) begin
                    n_state = tcf_pkg::S_OUT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = tcf_pkg::S_MUL_RATE;
                end
            end
            tcf_pkg::S_OUT: begin
                // wait until the previous word has left the output register
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = tcf_pkg::OP_OUT;
                    n_state  = tcf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcf_pkg::S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || (o_cmd.op == tcf_pkg::OP_OUT);
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/tcf_datapath.sv -----
module tcf_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcf_pkg::t_dp_cmd                    i_cmd,
    input  logic                                i_cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_accel_x,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_accel_y,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_accel_z,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_rate_x,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_rate_y,
    output logic signed [tcf_pkg::DATA_W-1:0]   o_tilt_x,
    output logic signed [tcf_pkg::DATA_W-1:0]   o_tilt_y
);

    // configuration
    logic        [tcf_pkg::ALPHA_W-1:0] r_alpha;
    logic        [tcf_pkg::GAIN_W-1:0]  r_gain;
    logic signed [tcf_pkg::DATA_W-1:0]  r_off_ax, r_off_ay, r_off_az;
    logic signed [tcf_pkg::DATA_W-1:0]  r_off_rx, r_off_ry;

    // filter state
    logic signed [tcf_pkg::DATA_W-1:0]  r_fa [2];

    // per-item working registers
    logic signed [tcf_pkg::XY_W-1:0]    r_x [2];
    logic signed [tcf_pkg::XY_W-1:0]    r_y [2];
    logic signed [tcf_pkg::ACC_W-1:0]   r_acc [2];
    logic                               r_zero [2];
    logic signed [tcf_pkg::RATE_W-1:0]  r_rate [2];
    logic signed [tcf_pkg::DATA_W-1:0]  r_ang [2];
    logic signed [tcf_pkg::PROD_W-1:0]  r_prod;
    logic signed [tcf_pkg::DIFF_W-1:0]  r_d;
    logic signed [tcf_pkg::MIX_W-1:0]   r_mix;
    logic signed [tcf_pkg::DATA_W-1:0]  r_tilt_x, r_tilt_y;

    // combinational
    logic signed [tcf_pkg::DATA_W-1:0]  w_az;
    logic signed [tcf_pkg::DATA_W-1:0]  w_a [2];
    logic signed [tcf_pkg::XY_W-1:0]    w_zs;
    logic signed [tcf_pkg::XY_W-1:0]    w_as [2];
    logic signed [tcf_pkg::XY_W-1:0]    n_x0 [2];
    logic signed [tcf_pkg::XY_W-1:0]    n_y0 [2];
    logic signed [tcf_pkg::ACC_W-1:0]   n_acc0 [2];
    logic                               n_zero0 [2];
    logic signed [tcf_pkg::RATE_W-1:0]  n_rate0 [2];
    logic signed [tcf_pkg::XY_W-1:0]    w_xs [2];
    logic signed [tcf_pkg::XY_W-1:0]    w_ys [2];
    logic signed [tcf_pkg::XY_W-1:0]    n_xc [2];
    logic signed [tcf_pkg::XY_W-1:0]    n_yc [2];
    logic signed [tcf_pkg::ACC_W-1:0]   n_accc [2];
    logic signed [tcf_pkg::ACC_W-1:0]   w_atan;
    logic signed [tcf_pkg::ACC_W-1:0]   w_rnd [2];
    logic signed [tcf_pkg::ACC_W-1:0]   w_rsh [2];
    logic signed [tcf_pkg::DATA_W-1:0]  n_ang [2];
    logic signed [tcf_pkg::MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [tcf_pkg::PROD_W-1:0]  w_prod;
    logic signed [tcf_pkg::DIFF_W-1:0]  w_fa_s, w_ang_s, n_d;
    logic signed [tcf_pkg::MIX_W-1:0]   n_mix_init, n_mix_acc;
    logic signed [tcf_pkg::DATA_W-1:0]  n_fa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= tcf_pkg::ALPHA_RESET;
            r_gain   <= tcf_pkg::GAIN_RESET;
            r_off_ax <= '0;
            r_off_ay <= '0;
            r_off_az <= '0;
            r_off_rx <= '0;
            r_off_ry <= '0;
        end else if (i_cfg_we) begin
            case (tcf_pkg::t_cfg_reg'(i_cfg_index))
                tcf_pkg::CFG_BLEND_WEIGHT:   r_alpha  <= i_cfg_data[tcf_pkg::ALPHA_W-1:0];
                tcf_pkg::CFG_GYRO_STEP_GAIN: r_gain   <= i_cfg_data[tcf_pkg::GAIN_W-1:0];
                tcf_pkg::CFG_ACCEL_OFFSET_X: r_off_ax <= i_cfg_data[tcf_pkg::DATA_W-1:0];
                tcf_pkg::CFG_ACCEL_OFFSET_Y: r_off_ay <= i_cfg_data[tcf_pkg::DATA_W-1:0];
                tcf_pkg::CFG_ACCEL_OFFSET_Z: r_off_az <= i_cfg_data[tcf_pkg::DATA_W-1:0];
                tcf_pkg::CFG_RATE_OFFSET_X:  r_off_rx <= i_cfg_data[tcf_pkg::DATA_W-1:0];
                tcf_pkg::CFG_RATE_OFFSET_Y:  r_off_ry <= i_cfg_data[tcf_pkg::DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // load: bias removal and quadrant fold for z < 0
    always_comb begin
        w_az = i_accel_z - r_off_az;
        w_a[0] = i_accel_x - r_off_ax;
        w_a[1] = i_accel_y - r_off_ay;
        n_rate0[0] = tcf_pkg::RATE_W'(i_rate_x) - tcf_pkg::RATE_W'(r_off_rx);
        n_rate0[1] = tcf_pkg::RATE_W'(i_rate_y) - tcf_pkg::RATE_W'(r_off_ry);
        w_zs = tcf_pkg::XY_W'(w_az) <<< tcf_pkg::PRE_SHIFT;
        for (int k = 0; k < 2; k++) begin
            w_as[k] = tcf_pkg::XY_W'(w_a[k]) <<< tcf_pkg::PRE_SHIFT;
            n_zero0[k] = (w_a[k] == 0) && (w_az == 0);
            if (w_az < 0) begin
                if (w_a[k] >= 0) begin
                    n_x0[k]   = w_as[k];
                    n_y0[k]   = -w_zs;
                    n_acc0[k] = tcf_pkg::ACC_QUARTER;
                end else begin
                    n_x0[k]   = -w_as[k];
                    n_y0[k]   = w_zs;
                    n_acc0[k] = -tcf_pkg::ACC_QUARTER;
                end
            end else begin
                n_x0[k]   = w_zs;
                n_y0[k]   = w_as[k];
                n_acc0[k] = '0;
            end
        end
    end

    // one vectoring step per cycle, both axes side by side
    always_comb begin
        w_atan = tcf_pkg::ACC_W'(
            tcf_pkg::atan_deg_q16(tcf_pkg::ATAN_IDX_W'(i_cmd.step)));
        for (int k = 0; k < 2; k++) begin
            w_xs[k] = r_x[k] >>> i_cmd.step;
            w_ys[k] = r_y[k] >>> i_cmd.step;
            if (r_y[k] > 0) begin
                n_xc[k]   = r_x[k] + w_ys[k];
                n_yc[k]   = r_y[k] - w_xs[k];
                n_accc[k] = r_acc[k] + w_atan;
            end else begin
                n_xc[k]   = r_x[k] - w_ys[k];
                n_yc[k]   = r_y[k] + w_xs[k];
                n_accc[k] = r_acc[k] - w_atan;
            end
            w_rnd[k] = r_acc[k] + tcf_pkg::ACC_W'(tcf_pkg::ROUND_BIAS);
            w_rsh[k] = w_rnd[k] >>> tcf_pkg::ROUND_SHIFT;
            n_ang[k] = r_zero[k] ? '0 : tcf_pkg::sat16(tcf_pkg::SAT_IN_W'(w_rsh[k]));
        end
    end

    // shared multiplier and blend arithmetic
    always_comb begin
        case (i_cmd.op)
            tcf_pkg::OP_MUL_RATE: begin
                w_mul_a = tcf_pkg::MUL_W'(r_rate[i_cmd.axis]);
                w_mul_b = tcf_pkg::MUL_W'(r_gain);
            end
            tcf_pkg::OP_MUL_LO: begin
                w_mul_a = tcf_pkg::MUL_W'(r_alpha);
                w_mul_b = tcf_pkg::MUL_W'(r_d[tcf_pkg::FRAC_SPLIT-1:0]);
            end
            tcf_pkg::OP_MUL_HI: begin
                w_mul_a = tcf_pkg::MUL_W'(r_alpha);
                w_mul_b = tcf_pkg::MUL_W'($signed(r_d[tcf_pkg::DIFF_W-1:tcf_pkg::FRAC_SPLIT]));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod = w_mul_a * w_mul_b;

        // d = predicted angle minus accel angle, both in Q16
        w_fa_s  = tcf_pkg::DIFF_W'(r_fa[i_cmd.axis]) <<< tcf_pkg::Q16_SHIFT;
        w_ang_s = tcf_pkg::DIFF_W'(r_ang[i_cmd.axis]) <<< tcf_pkg::Q16_SHIFT;
        n_d     = w_fa_s + tcf_pkg::DIFF_W'(r_prod) - w_ang_s;

        // mix = alpha*d + accel angle in Q32, with the rounding half folded in
        n_mix_init = (tcf_pkg::MIX_W'(r_ang[i_cmd.axis]) <<< tcf_pkg::MIX_SHIFT)
                   + tcf_pkg::MIX_W'(r_prod) + tcf_pkg::MIX_HALF;
        n_mix_acc  = r_mix + (tcf_pkg::MIX_W'(r_prod) <<< tcf_pkg::FRAC_SPLIT);
        n_fa = tcf_pkg::sat16(tcf_pkg::SAT_IN_W'(
            $signed(r_mix[tcf_pkg::MIX_W-1:tcf_pkg::MIX_SHIFT])));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa[0] <= '0;
            r_fa[1] <= '0;
        end else if (i_cmd.op == tcf_pkg::OP_STORE) begin
            r_fa[i_cmd.axis] <= n_fa;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tcf_pkg::OP_LOAD: begin
                for (int k = 0; k < 2; k++) begin
                    r_x[k]    <= n_x0[k];
                    r_y[k]    <= n_y0[k];
                    r_acc[k]  <= n_acc0[k];
                    r_zero[k] <= n_zero0[k];
                    r_rate[k] <= n_rate0[k];
                end
            end
            tcf_pkg::OP_CORDIC: begin
                for (int k = 0; k < 2; k++) begin
                    r_x[k]   <= n_xc[k];
                    r_y[k]   <= n_yc[k];
                    r_acc[k] <= n_accc[k];
                end
            end
            tcf_pkg::OP_ROUND: begin
                r_ang[0] <= n_ang[0];
                r_ang[1] <= n_ang[1];
            end
            tcf_pkg::OP_MUL_RATE, tcf_pkg::OP_MUL_LO: begin
                r_prod <= w_prod;
            end
            tcf_pkg::OP_DIFF: begin
                r_d <= n_d;
            end
            tcf_pkg::OP_MUL_HI: begin
                r_prod <= w_prod;
                r_mix  <= n_mix_init;
            end
            tcf_pkg::OP_ACC: begin
                r_mix <= n_mix_acc;
            end
            tcf_pkg::OP_OUT: begin
                r_tilt_x <= r_fa[0];
                r_tilt_y <= r_fa[1];
            end
            default: begin
            end
        endcase
    end

    assign o_tilt_x = r_tilt_x;
    assign o_tilt_y = r_tilt_y;

endmodule

// ----- hw/rtl/tilt_complementary_filter_top.sv -----
// an accepted word is loaded, run through the iterative cordic and rounded, then each axis is
// blended (rate multiply, diff, low and high multiply, accumulate, store) before the output write;
//   the pace is set by the cordic (one step per cycle, both axes in parallel) and the shared 21x21 multiplier
// output register holds a finished word while the next one is accepted and computed
// reset: synchronous active low; restores register defaults and clears both stored angles
module tilt_complementary_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_accel_x,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_accel_y,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_accel_z,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_rate_x,
    input  logic signed [tcf_pkg::DATA_W-1:0]   i_rate_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tcf_pkg::DATA_W-1:0]   o_tilt_x,
    output logic signed [tcf_pkg::DATA_W-1:0]   o_tilt_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    tcf_pkg::t_dp_cmd w_cmd;
    logic             w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    tcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    tcf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_rate_x    (i_rate_x),
        .i_rate_y    (i_rate_y),
        .o_tilt_x    (o_tilt_x),
        .o_tilt_y    (o_tilt_y)
    );

endmodule
